/* design/mhtq_pkg.sv */
package mhtq_pkg;

	// Sizes of the queue.
	localparam int CAPACITY = 32;
	localparam int ID_W = 10;
	localparam int ID_COUNT = 1 << ID_W;
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KID_W = SLOT_W + 2;
	localparam int EXP_W = 32;
	localparam int TMO_W = 24;
	localparam int LEFT_W = 24;
	localparam int RES_W = 2;
	localparam int KIND_W = 2;

	// Slot table entry that can never be below the pending count.
	localparam logic [CNT_W-1:0] SLOT_NONE = '1;

	// Input kinds.
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

	// Result codes.
	localparam logic [RES_W-1:0] RES_EXPIRED = 2'd0;
	localparam logic [RES_W-1:0] RES_FIRED = 2'd1;
	localparam logic [RES_W-1:0] RES_DONE = 2'd2;
	localparam logic [RES_W-1:0] RES_FULL = 2'd3;

	typedef struct packed {
		logic [EXP_W-1:0] expiry;
		logic [ID_W-1:0] ident;
	} heap_ent_t;

	// One timer event to be buffered until the step is complete.
	typedef struct packed {
		logic valid;
		logic [RES_W-1:0] res;
		logic [ID_W-1:0] id;
	} ev_push_t;

	// Closing status of a step; start begins the output of the buffered items.
	typedef struct packed {
		logic start;
		logic [RES_W-1:0] res;
		logic [CNT_W-1:0] pending;
		logic has_next;
		logic [LEFT_W-1:0] left;
	} stat_t;

endpackage

/* design/min_heap_timer_queue.sv */
// Timer queue over a binary min-heap of up to 32 timers keyed by expiry time,
// with a 1024-entry table from timer id to heap slot. Items enter on the
// s_ side (tuser = kind: tick, set, fire, clear) and results leave on the m_
// side; every item ends with one status item marked by tlast, preceded by one
// item per expired or fired timer. The block takes one item at a time: a
// step walks the heap level by level, downward and upward, with one registered
// memory read and one compare in the shared time comparator per visited slot,
// and its result items are sent once the step is complete, as the receiver
// takes them. After reset a clearing pass writes every entry of the id table
// before the first item is taken.
module min_heap_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // timer_id, timeout_ms
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // event_id, pending, has_next, next_left_ms
	output logic [1:0]  m_tuser,   // event_res
	output logic        m_tlast
);

	localparam logic [4:0] ST_CLR = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_T_RD = 5'd2;
	localparam logic [4:0] ST_T_CK = 5'd3;
	localparam logic [4:0] ST_LK1 = 5'd4;
	localparam logic [4:0] ST_LK2 = 5'd5;
	localparam logic [4:0] ST_RM = 5'd6;
	localparam logic [4:0] ST_RM2 = 5'd7;
	localparam logic [4:0] ST_DN = 5'd8;
	localparam logic [4:0] ST_DN1 = 5'd9;
	localparam logic [4:0] ST_DN2 = 5'd10;
	localparam logic [4:0] ST_DN3 = 5'd11;
	localparam logic [4:0] ST_DN_END = 5'd12;
	localparam logic [4:0] ST_UP = 5'd13;
	localparam logic [4:0] ST_UP1 = 5'd14;
	localparam logic [4:0] ST_UP_END = 5'd15;
	localparam logic [4:0] ST_FIN = 5'd16;
	localparam logic [4:0] ST_FIN2 = 5'd17;
	localparam logic [4:0] ST_OUT = 5'd18;

	logic [4:0] state_q;
	logic [mhtq_pkg::ID_W-1:0] clr_q;
	logic [mhtq_pkg::EXP_W-1:0] now_q;
	logic [mhtq_pkg::CNT_W-1:0] count_q;
	logic [mhtq_pkg::KIND_W-1:0] kind_q;
	logic [mhtq_pkg::ID_W-1:0] id_q;
	logic [mhtq_pkg::TMO_W-1:0] tmo_q;
	logic rej_q;
	logic [mhtq_pkg::EXP_W-1:0] cur_exp_q;
	logic [mhtq_pkg::ID_W-1:0] cur_id_q;
	logic [mhtq_pkg::SLOT_W-1:0] pos_q;
	logic [mhtq_pkg::SLOT_W-1:0] start_q;
	logic [mhtq_pkg::CNT_W-1:0] limit_q;
	mhtq_pkg::heap_ent_t kent_q;
	logic [mhtq_pkg::SLOT_W-1:0] kidx_q;

	// Memories and their ports.
	mhtq_pkg::heap_ent_t heap_mem [mhtq_pkg::CAPACITY];
	logic [mhtq_pkg::CNT_W-1:0] slot_mem [mhtq_pkg::ID_COUNT];
	mhtq_pkg::heap_ent_t hrd_q;
	logic [mhtq_pkg::CNT_W-1:0] srd_q;
	logic hwe;
	logic [mhtq_pkg::SLOT_W-1:0] hwa;
	logic [mhtq_pkg::SLOT_W-1:0] hra;
	mhtq_pkg::heap_ent_t hwd;
	logic swe;
	logic [mhtq_pkg::ID_W-1:0] swa;
	logic [mhtq_pkg::CNT_W-1:0] swd;

	// Derived indexes and compare unit connections.
	logic [mhtq_pkg::CNT_W-1:0] tail;
	logic [mhtq_pkg::KID_W-1:0] kid1;
	logic [mhtq_pkg::KID_W-1:0] kid2;
	logic [mhtq_pkg::KID_W-1:0] limit_x;
	logic [mhtq_pkg::SLOT_W-1:0] up;
	logic [mhtq_pkg::EXP_W-1:0] cmp_a;
	logic [mhtq_pkg::EXP_W-1:0] cmp_b;
	logic earl;
	logic due;
	logic [mhtq_pkg::LEFT_W-1:0] left;
	logic [mhtq_pkg::EXP_W-1:0] new_exp;
	logic full;
	logic accept;
	logic found;
	mhtq_pkg::ev_push_t push;
	mhtq_pkg::stat_t stat;
	logic evq_busy;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign tail = count_q - 1'b1;
	assign kid1 = {1'b0, pos_q, 1'b1};
	assign kid2 = kid1 + 1'b1;
	assign limit_x = mhtq_pkg::KID_W'(limit_q);
	assign up = (pos_q - 1'b1) >> 1;
	assign new_exp = now_q + mhtq_pkg::EXP_W'(tmo_q);
	assign full = (count_q >= mhtq_pkg::CNT_W'(mhtq_pkg::CAPACITY));
	assign found = (hrd_q.ident == id_q);

	// Operand selection for the shared comparator.
	always_comb begin
		case (state_q)
			ST_DN2: begin
				cmp_a = hrd_q.expiry;
				cmp_b = kent_q.expiry;
			end
			ST_DN3: begin
				cmp_a = cur_exp_q;
				cmp_b = kent_q.expiry;
			end
			ST_UP1: begin
				cmp_a = hrd_q.expiry;
				cmp_b = cur_exp_q;
			end
			default: begin
				cmp_a = hrd_q.expiry;
				cmp_b = now_q;
			end
		endcase
	end

	mhtq_cmp u_cmp (
		.a       (cmp_a),
		.b       (cmp_b),
		.earlier (earl),
		.due     (due),
		.left    (left)
	);

	// Heap read address per state.
	always_comb begin
		case (state_q)
			ST_LK1: hra = srd_q[mhtq_pkg::SLOT_W-1:0];
			ST_RM: hra = tail[mhtq_pkg::SLOT_W-1:0];
			ST_DN: hra = kid1[mhtq_pkg::SLOT_W-1:0];
			ST_DN1: hra = kid2[mhtq_pkg::SLOT_W-1:0];
			ST_UP: hra = up;
			default: hra = '0;
		endcase
	end

	// Heap and slot table writes: an entry moved into the hole, or the
	// moving timer placed at its final slot, or the clearing pass.
	always_comb begin
		hwe = 1'b0;
		hwa = pos_q;
		hwd = '{expiry: cur_exp_q, ident: cur_id_q};
		swe = 1'b0;
		swa = cur_id_q;
		swd = mhtq_pkg::CNT_W'(pos_q);
		case (state_q)
			ST_CLR: begin
				swe = 1'b1;
				swa = clr_q;
				swd = mhtq_pkg::SLOT_NONE;
			end
			ST_DN3: begin
				hwe = !earl;
				swe = !earl;
				hwd = kent_q;
				swa = kent_q.ident;
			end
			ST_DN_END: begin
				hwe = (pos_q > start_q);
				swe = (pos_q > start_q);
			end
			ST_UP1: begin
				hwe = !earl;
				swe = !earl;
				hwd = hrd_q;
				swa = hrd_q.ident;
			end
			ST_UP_END: begin
				hwe = 1'b1;
				swe = 1'b1;
			end
			default: begin
				hwe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hwe) begin
			heap_mem[hwa] <= hwd;
		end
		hrd_q <= heap_mem[hra];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			slot_mem[swa] <= swd;
		end
		srd_q <= slot_mem[s_tdata[mhtq_pkg::ID_W-1:0]];
	end

	// Events and closing status toward the output stage.
	always_comb begin
		push = '0;
		stat = '0;
		stat.res = rej_q ? mhtq_pkg::RES_FULL : mhtq_pkg::RES_DONE;
		stat.pending = count_q;
		if (state_q == ST_T_CK && due) begin
			push.valid = 1'b1;
			push.res = mhtq_pkg::RES_EXPIRED;
			push.id = hrd_q.ident;
		end
		if (state_q == ST_LK2 && found && kind_q == mhtq_pkg::KIND_FIRE) begin
			push.valid = 1'b1;
			push.res = mhtq_pkg::RES_FIRED;
			push.id = id_q;
		end
		if (state_q == ST_FIN && count_q == '0) begin
			stat.start = 1'b1;
		end
		if (state_q == ST_FIN2) begin
			stat.start = 1'b1;
			stat.has_next = 1'b1;
			stat.left = left;
		end
	end

	mhtq_evq u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.stat     (stat),
		.busy     (evq_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			now_q <= '0;
			count_q <= '0;
			rej_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						kind_q <= s_tuser;
						id_q <= s_tdata[mhtq_pkg::ID_W-1:0];
						tmo_q <= s_tdata[mhtq_pkg::ID_W+mhtq_pkg::TMO_W-1:mhtq_pkg::ID_W];
						rej_q <= 1'b0;
						case (s_tuser)
							mhtq_pkg::KIND_TICK: begin
								now_q <= now_q + 1'b1;
								state_q <= ST_T_RD;
							end
							mhtq_pkg::KIND_CLEAR: begin
								count_q <= '0;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_LK1;
							end
						endcase
					end
				end
				ST_T_RD: begin
					state_q <= (count_q == '0) ? ST_FIN : ST_T_CK;
				end
				ST_T_CK: begin
					if (due) begin
						pos_q <= '0;
						state_q <= ST_RM;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_LK1, ST_LK2: begin
					if (state_q == ST_LK1 && srd_q < count_q) begin
						pos_q <= srd_q[mhtq_pkg::SLOT_W-1:0];
						state_q <= ST_LK2;
					end else if (state_q == ST_LK2 && found) begin
						if (kind_q == mhtq_pkg::KIND_SET) begin
							cur_exp_q <= new_exp;
							cur_id_q <= id_q;
							start_q <= pos_q;
							limit_q <= count_q;
							state_q <= ST_DN;
						end else begin
							state_q <= ST_RM;
						end
					end else if (kind_q == mhtq_pkg::KIND_SET) begin
						// Unknown id: append a new timer unless the heap is full.
						if (full) begin
							rej_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							pos_q <= count_q[mhtq_pkg::SLOT_W-1:0];
							cur_exp_q <= new_exp;
							cur_id_q <= id_q;
							count_q <= count_q + 1'b1;
							state_q <= ST_UP;
						end
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_RM: begin
					// Remove at pos: the tail timer refills the hole.
					count_q <= tail;
					limit_q <= tail;
					start_q <= pos_q;
					if (mhtq_pkg::CNT_W'(pos_q) < tail) begin
						state_q <= ST_RM2;
					end else begin
						state_q <= (kind_q == mhtq_pkg::KIND_TICK) ? ST_T_RD : ST_FIN;
					end
				end
				ST_RM2: begin
					cur_exp_q <= hrd_q.expiry;
					cur_id_q <= hrd_q.ident;
					state_q <= ST_DN;
				end
				ST_DN: begin
					state_q <= (kid1 < limit_x) ? ST_DN1 : ST_DN_END;
				end
				ST_DN1: begin
					kent_q <= hrd_q;
					kidx_q <= kid1[mhtq_pkg::SLOT_W-1:0];
					state_q <= (kid2 < limit_x) ? ST_DN2 : ST_DN3;
				end
				ST_DN2: begin
					// Right child wins only when strictly earlier.
					if (earl) begin
						kent_q <= hrd_q;
						kidx_q <= kid2[mhtq_pkg::SLOT_W-1:0];
					end
					state_q <= ST_DN3;
				end
				ST_DN3: begin
					if (earl) begin
						state_q <= ST_DN_END;
					end else begin
						pos_q <= kidx_q;
						state_q <= ST_DN;
					end
				end
				ST_DN_END: begin
					if (pos_q > start_q) begin
						state_q <= (kind_q == mhtq_pkg::KIND_TICK) ? ST_T_RD : ST_FIN;
					end else begin
						state_q <= ST_UP;
					end
				end
				ST_UP: begin
					state_q <= (pos_q == '0) ? ST_UP_END : ST_UP1;
				end
				ST_UP1: begin
					if (earl) begin
						state_q <= ST_UP_END;
					end else begin
						pos_q <= up;
						state_q <= ST_UP;
					end
				end
				ST_UP_END: begin
					state_q <= (kind_q == mhtq_pkg::KIND_TICK) ? ST_T_RD : ST_FIN;
				end
				ST_FIN: begin
					state_q <= (count_q == '0) ? ST_OUT : ST_FIN2;
				end
				ST_FIN2: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!evq_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted item did not start a step");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (count_q <= mhtq_pkg::CNT_W'(mhtq_pkg::CAPACITY)))
		else $error("pending count above capacity");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("item taken while results still pending");
	a_down_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DN3 && !earl) |=> (pos_q > $past(pos_q)))
		else $error("sift-down did not descend");
`endif

endmodule

/* design/mhtq_cmp.sv */
// Shared time compare unit: one wrapping subtract a - b.
module mhtq_cmp (
	input  logic [mhtq_pkg::EXP_W-1:0]  a,
	input  logic [mhtq_pkg::EXP_W-1:0]  b,
	output logic                        earlier,
	output logic                        due,
	output logic [mhtq_pkg::LEFT_W-1:0] left
);

	logic [mhtq_pkg::EXP_W-1:0] diff;

	// The sign of the difference orders the two times.
	always_comb begin
		diff = a - b;
		earlier = diff[mhtq_pkg::EXP_W-1];
		due = earlier || (diff == '0);
		if (earlier) begin
			left = '0;
		end else if (|diff[mhtq_pkg::EXP_W-1:mhtq_pkg::LEFT_W]) begin
			left = '1;
		end else begin
			left = diff[mhtq_pkg::LEFT_W-1:0];
		end
	end

endmodule

/* design/mhtq_evq.sv */
// Event buffer and output stage: holds the events of one step, then sends
// them followed by the status item once the step is complete.
module mhtq_evq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mhtq_pkg::ev_push_t   push,
	input  mhtq_pkg::stat_t      stat,
	output logic                 busy,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,   // event_id, pending, has_next, next_left_ms
	output logic [1:0]           m_tuser,   // event_res
	output logic                 m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD = 2'd1;
	localparam logic [1:0] ST_LD = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;
	logic [mhtq_pkg::CNT_W-1:0] wcnt_q;
	logic [mhtq_pkg::CNT_W-1:0] rcnt_q;
	logic [mhtq_pkg::RES_W+mhtq_pkg::ID_W-1:0] ev_mem [mhtq_pkg::CAPACITY];
	logic [mhtq_pkg::RES_W+mhtq_pkg::ID_W-1:0] rdata_q;
	mhtq_pkg::stat_t stat_q;
	logic valid_q;
	logic last_q;
	logic [mhtq_pkg::RES_W-1:0] res_q;
	logic [mhtq_pkg::ID_W-1:0] id_q;

	// Event memory, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			ev_mem[wcnt_q[mhtq_pkg::SLOT_W-1:0]] <= {push.res, push.id};
		end
		rdata_q <= ev_mem[rcnt_q[mhtq_pkg::SLOT_W-1:0]];
	end

	// Output sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wcnt_q <= '0;
			rcnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (push.valid) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (stat.start) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (rcnt_q < wcnt_q) begin
						state_q <= ST_LD;
					end else begin
						res_q <= stat_q.res;
						id_q <= '0;
						last_q <= 1'b1;
						valid_q <= 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_LD: begin
					res_q <= rdata_q[mhtq_pkg::RES_W+mhtq_pkg::ID_W-1:mhtq_pkg::ID_W];
					id_q <= rdata_q[mhtq_pkg::ID_W-1:0];
					last_q <= 1'b0;
					valid_q <= 1'b1;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (m_tready) begin
						valid_q <= 1'b0;
						if (last_q) begin
							wcnt_q <= '0;
							rcnt_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							rcnt_q <= rcnt_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Status of the step, captured at its end.
	always_ff @(posedge clk) begin
		if (stat.start) begin
			stat_q <= stat;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign m_tvalid = valid_q;
	assign m_tuser = res_q;
	assign m_tlast = last_q;
	assign m_tdata = {7'b0, stat_q.left, stat_q.has_next, stat_q.pending, id_q};

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (state_q == ST_IDLE && wcnt_q == '0))
		else $error("buffer not emptied after final item");
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD) |-> (rcnt_q < wcnt_q))
		else $error("read beyond buffered events");
	a_wcnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= mhtq_pkg::CNT_W'(mhtq_pkg::CAPACITY))
		else $error("event buffer overflow");
`endif

endmodule

/* sim/min_heap_timer_queue_test.sv */
module min_heap_timer_queue_test;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 406;

	// One result item as the block should send it.
	typedef struct {
		logic [mhtq_pkg::RES_W-1:0] res;
		logic [mhtq_pkg::ID_W-1:0] id;
		logic [5:0] pending;
		logic has_next;
		logic [mhtq_pkg::LEFT_W-1:0] left;
		logic last;
	} timer_event_t;

	// Mirror of the timer heap that predicts the result items of every accepted item.
	class timer_scoreboard;
		logic [31:0] now_ms;
		logic [31:0] expiry[mhtq_pkg::CAPACITY];
		logic [mhtq_pkg::ID_W-1:0] ident[mhtq_pkg::CAPACITY];
		int slot_of[mhtq_pkg::ID_COUNT];
		bit known[mhtq_pkg::ID_COUNT];
		int count;
		timer_event_t pending_events[$];
		int errors;
		int inputs_seen;
		int results_seen;
		int expired_seen;
		int rejected_seen;
		int peak_count;

		function new();
			now_ms = '0;
			count = 0;
			errors = 0;
			inputs_seen = 0;
			results_seen = 0;
			expired_seen = 0;
			rejected_seen = 0;
			peak_count = 0;
			foreach (known[i]) known[i] = 0;
		endfunction

		function bit earlier(int a, int b);
			logic [31:0] diff;
			diff = expiry[a] - expiry[b];
			return diff[31];
		endfunction

		function void swap_slots(int a, int b);
			logic [31:0] e;
			logic [mhtq_pkg::ID_W-1:0] d;
			e = expiry[a];
			d = ident[a];
			expiry[a] = expiry[b];
			ident[a] = ident[b];
			expiry[b] = e;
			ident[b] = d;
			slot_of[ident[a]] = a;
			slot_of[ident[b]] = b;
		endfunction

		function void sift_up(int pos);
			int up;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (earlier(up, pos)) break;
				swap_slots(pos, up);
				pos = up;
			end
		endfunction

		function bit sift_down(int start, int limit);
			int pos;
			int kid;
			pos = start;
			kid = 2 * pos + 1;
			while (kid < limit) begin
				if (kid + 1 < limit && earlier(kid + 1, kid)) kid++;
				if (earlier(pos, kid)) break;
				swap_slots(pos, kid);
				pos = kid;
				kid = 2 * pos + 1;
			end
			return pos > start;
		endfunction

		function void remove_slot(int pos);
			int tail;
			tail = count - 1;
			if (pos < tail) begin
				swap_slots(pos, tail);
				if (!sift_down(pos, tail)) sift_up(pos);
			end
			known[ident[tail]] = 0;
			count = tail;
		endfunction

		function void add_event(ref timer_event_t evs[$],
				input logic [mhtq_pkg::RES_W-1:0] res,
				input logic [mhtq_pkg::ID_W-1:0] id);
			timer_event_t ev;
			ev.res = res;
			ev.id = id;
			ev.pending = '0;
			ev.has_next = 0;
			ev.left = '0;
			ev.last = 0;
			evs.insert(evs.size(), ev);
		endfunction

		// Apply one accepted item and queue the result items it causes.
		function void note_input(logic [mhtq_pkg::KIND_W-1:0] kind,
				logic [mhtq_pkg::ID_W-1:0] id, logic [mhtq_pkg::TMO_W-1:0] tmo);
			timer_event_t evs[$];
			bit rejected;
			logic [31:0] d;
			logic [mhtq_pkg::LEFT_W-1:0] left;
			int pos;
			rejected = 0;
			inputs_seen++;
			case (kind)
				mhtq_pkg::KIND_TICK: begin
					now_ms = now_ms + 1;
					while (count > 0) begin
						d = expiry[0] - now_ms;
						if (!(d == 0 || d[31])) break;
						add_event(evs, mhtq_pkg::RES_EXPIRED, ident[0]);
						expired_seen++;
						remove_slot(0);
					end
				end
				mhtq_pkg::KIND_SET: begin
					if (known[id]) begin
						pos = slot_of[id];
						if (pos < count) begin
							expiry[pos] = now_ms + tmo;
							if (!sift_down(pos, count)) sift_up(pos);
						end
					end else if (count >= mhtq_pkg::CAPACITY) begin
						rejected = 1;
						rejected_seen++;
					end else begin
						pos = count;
						expiry[pos] = now_ms + tmo;
						ident[pos] = id;
						slot_of[id] = pos;
						known[id] = 1;
						count = pos + 1;
						sift_up(pos);
					end
				end
				mhtq_pkg::KIND_FIRE: begin
					if (known[id] && slot_of[id] < count) begin
						add_event(evs, mhtq_pkg::RES_FIRED, id);
						remove_slot(slot_of[id]);
					end
				end
				default: begin
					count = 0;
					foreach (known[i]) known[i] = 0;
				end
			endcase
			add_event(evs, rejected ? mhtq_pkg::RES_FULL : mhtq_pkg::RES_DONE, '0);
			if (count > peak_count) peak_count = count;

			// Status fields are shared by every item of this step.
			left = '0;
			if (count > 0) begin
				d = expiry[0] - now_ms;
				if (d[31]) left = '0;
				else if (d > 32'hFFFFFF) left = '1;
				else left = d[mhtq_pkg::LEFT_W-1:0];
			end
			foreach (evs[k]) begin
				evs[k].pending = count[5:0];
				evs[k].has_next = count > 0;
				evs[k].left = left;
				evs[k].last = (k == evs.size() - 1);
				pending_events.insert(pending_events.size(), evs[k]);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("mismatch: %s", what);
		endtask

		// Compare one accepted result item with the oldest prediction.
		task check_result(logic [mhtq_pkg::RES_W-1:0] res, logic [47:0] data, logic last);
			timer_event_t ev;
			results_seen++;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected result res=%0d data=%h", res, data));
				return;
			end
			ev = pending_events.pop_front();
			if (res !== ev.res)
				report_mismatch($sformatf("event_res %0d, predicted %0d", res, ev.res));
			if (data[9:0] !== ev.id)
				report_mismatch($sformatf("event_id %0d, predicted %0d", data[9:0], ev.id));
			if (data[15:10] !== ev.pending)
				report_mismatch($sformatf("pending %0d, predicted %0d", data[15:10],
					ev.pending));
			if (data[16] !== ev.has_next)
				report_mismatch($sformatf("has_next %b, predicted %b", data[16], ev.has_next));
			if (data[40:17] !== ev.left)
				report_mismatch($sformatf("next_left_ms %0d, predicted %0d", data[40:17],
					ev.left));
			if (data[47:41] !== '0)
				report_mismatch($sformatf("padding bits %h are not zero", data[47:41]));
			if (last !== ev.last)
				report_mismatch($sformatf("last %b, predicted %b", last, ev.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	timer_scoreboard sb;
	bit hold_go;
	int idle_cycles;
	logic [mhtq_pkg::ID_W-1:0] id_pool[48];

	min_heap_timer_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Note accepted items on both sides.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tuser, s_tdata[9:0], s_tdata[33:10]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata, m_tlast);
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver: changing stall patterns, plus one long hold-off on request.
	initial begin
		int mode;
		m_tready <= 0;
		@(posedge arst_n);
		forever begin
			if (hold_go) begin
				hold_go = 0;
				m_tready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(16, 80)) begin
				case (mode)
					0: m_tready <= 1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 7) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Offer one item and wait until it is taken; valid stays high for the next item.
	task send_item(logic [mhtq_pkg::KIND_W-1:0] kind, logic [mhtq_pkg::ID_W-1:0] id,
			logic [mhtq_pkg::TMO_W-1:0] tmo);
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {6'd0, tmo, id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task gap_maybe();
		int gap;
		if ($urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function logic [mhtq_pkg::ID_W-1:0] pick_id();
		if ($urandom_range(0, 4) == 0)
			return mhtq_pkg::ID_W'($urandom_range(0, mhtq_pkg::ID_COUNT - 1));
		return id_pool[$urandom_range(0, 47)];
	endfunction

	function logic [mhtq_pkg::TMO_W-1:0] pick_timeout();
		case ($urandom_range(0, 9))
			0: return mhtq_pkg::TMO_W'($urandom);
			1: return '1;
			2: return '0;
			default: return mhtq_pkg::TMO_W'($urandom_range(0, 40));
		endcase
	endfunction

	initial begin
		int r;
		sb = new();
		hold_go = 0;
		idle_cycles = 0;
		s_tvalid <= 0;
		s_tdata <= '0;
		s_tuser <= mhtq_pkg::KIND_TICK;
		arst_n <= 0;
		foreach (id_pool[i])
			id_pool[i] = mhtq_pkg::ID_W'($urandom_range(0, mhtq_pkg::ID_COUNT - 1));
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: empty queue, extremes, ties, rearm, unknown fire, full heap.
		send_item(mhtq_pkg::KIND_TICK, 10'd0, 24'd0);
		send_item(mhtq_pkg::KIND_SET, 10'd0, 24'd0);
		send_item(mhtq_pkg::KIND_TICK, 10'd0, 24'd0);
		send_item(mhtq_pkg::KIND_SET, 10'd1023, 24'hFFFFFF);
		send_item(mhtq_pkg::KIND_SET, 10'd5, 24'd3);
		send_item(mhtq_pkg::KIND_SET, 10'd6, 24'd3);
		send_item(mhtq_pkg::KIND_SET, 10'd5, 24'd10);
		send_item(mhtq_pkg::KIND_FIRE, 10'd1023, 24'd0);
		send_item(mhtq_pkg::KIND_FIRE, 10'd999, 24'hAAAAAA);
		repeat (4) send_item(mhtq_pkg::KIND_TICK, 10'd0, 24'd0);
		send_item(mhtq_pkg::KIND_CLEAR, 10'd0, 24'd0);
		for (int i = 0; i < mhtq_pkg::CAPACITY; i++)
			send_item(mhtq_pkg::KIND_SET, 10'(100 + i), 24'(2 + i % 3));
		send_item(mhtq_pkg::KIND_SET, 10'd700, 24'd1);
		send_item(mhtq_pkg::KIND_SET, 10'd100, 24'd0);
		repeat (5) send_item(mhtq_pkg::KIND_TICK, 10'd0, 24'd0);
		send_item(mhtq_pkg::KIND_CLEAR, 10'd0, 24'd0);

		// Random part; the long receiver hold-off starts with it.
		hold_go = 1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 48)
				send_item(mhtq_pkg::KIND_SET, pick_id(), pick_timeout());
			else if (r < 78)
				send_item(mhtq_pkg::KIND_TICK, mhtq_pkg::ID_W'($urandom),
					mhtq_pkg::TMO_W'($urandom));
			else if (r < 97)
				send_item(mhtq_pkg::KIND_FIRE, pick_id(), mhtq_pkg::TMO_W'($urandom));
			else
				send_item(mhtq_pkg::KIND_CLEAR, mhtq_pkg::ID_W'($urandom),
					mhtq_pkg::TMO_W'($urandom));
			gap_maybe();
		end
		s_tvalid <= 0;

		// Drain and let the block settle; the first edge lets the last item be noted.
		@(posedge clk);
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Covered %0d items, %0d results, %0d expiries, %0d rejected sets,",
			sb.inputs_seen, sb.results_seen, sb.expired_seen, sb.rejected_seen);
		$display("with up to %0d timers pending at once.", sb.peak_count);
		if (sb.errors == 0 && sb.pending_events.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/mhtq_pkg.sv
design/mhtq_cmp.sv
design/mhtq_evq.sv
design/min_heap_timer_queue.sv
sim/min_heap_timer_queue_test.sv
